// ===== sv/wsd_pkg.sv =====
// Package for the WAVE stream decoder: beat types, phase codes and file constants.
package wsd_pkg;

    // RIFF tags as they read little-endian
    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    // format tags
    localparam logic [15:0] FMT_PCM   = 16'h0001;
    localparam logic [15:0] FMT_FLOAT = 16'h0003;
    localparam logic [15:0] FMT_EXT   = 16'hFFFE;

    // minimum fmt body sizes, plain and extensible
    localparam logic [5:0] FMT_MIN_SIZE = 6'd16;
    localparam logic [5:0] EXT_MIN_SIZE = 6'd40;

    // result kinds
    typedef enum logic [1:0] {
        KIND_SAMPLE = 2'd0,
        KIND_FORMAT = 2'd1,
        KIND_FINISH = 2'd2
    } t_kind;

    // parser phases
    typedef enum logic [2:0] {
        PH_HEADER,
        PH_CHDR,
        PH_FMT,
        PH_DATA,
        PH_SKIP,
        PH_PAD,
        PH_DEAD
    } t_phase;

    // input beat
    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_file;
    } t_in_beat;

    // output beat
    typedef struct packed {
        t_kind              kind;
        logic signed [31:0] sample;
        logic [2:0]         channel;
        logic               last_of_run;
        logic [3:0]         format_channels;
        logic [31:0]        format_rate;
        logic [6:0]         format_bits;
        logic               format_is_float;
        logic               error;
        logic [31:0]        frame_count;
    } t_out_beat;

    // results raised by one byte, handed from parser to emitter
    typedef struct packed {
        logic        frame;
        logic        fmt;
        logic        fin;
        logic        fmt_err;
        logic        fin_err;
        logic [3:0]  chans;
        logic [31:0] rate;
        logic [6:0]  bits;
        logic        is_float;
        logic [31:0] frames;
    } t_grp;

endpackage

// ===== sv/wav_stream_decoder.sv =====
// Top level of the WAVE stream decoder: byte parser feeding the result emitter.
// Results of a byte appear on the output the cycle after that byte's beat.
// One byte per cycle while the output does not stall; a byte raising N results holds the input
// until the last of them is taken while the emitter drains them, one output beat per cycle.
// Reset: synchronous active low, returns the parser to the header phase and drops
// pending results; the frame store is not cleared.
module wav_stream_decoder #(
    parameter int MAX_CHANNELS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  wsd_pkg::t_in_beat  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output wsd_pkg::t_out_beat o_out_data
);

    localparam int IW   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CNTW = $clog2(MAX_CHANNELS + 1);

    wsd_pkg::t_grp   grp;
    logic            acc, any, wr_en;
    logic [CNTW-1:0] nsamp;
    logic [IW-1:0]   wr_idx;
    logic [31:0]     wr_data;

    wsd_parser #(.MAX_CHANNELS(MAX_CHANNELS), .IW(IW), .CNTW(CNTW)) u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_acc     (acc),
        .i_byte    (i_in_data.data_byte),
        .i_eof     (i_in_data.end_of_file),
        .o_grp     (grp),
        .o_any     (any),
        .o_nsamp   (nsamp),
        .o_wr_en   (wr_en),
        .o_wr_idx  (wr_idx),
        .o_wr_data (wr_data)
    );

    wsd_emitter #(.MAX_CHANNELS(MAX_CHANNELS), .IW(IW), .CNTW(CNTW)) u_emitter (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_acc       (acc),
        .i_grp       (grp),
        .i_any       (any),
        .i_nsamp     (nsamp),
        .i_wr_en     (wr_en),
        .i_wr_idx    (wr_idx),
        .i_wr_data   (wr_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== sv/wsd_conv.sv =====
// Sample converter: PCM and IEEE float words to Q1.31.
module wsd_conv (
    input  logic [63:0] i_raw,
    input  logic [6:0]  i_bits,
    input  logic        i_is_float,
    output logic [31:0] o_q31
);

    localparam logic [39:0] BIG = 40'hFF_FFFF_FFFF;

    // clamp a sign and magnitude to the Q1.31 range
    function automatic logic [31:0] sat_q31(input logic neg, input logic [63:0] mag);
        logic [31:0] res;
        if (!neg) begin
            res = (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
        end else begin
            res = (mag >= 64'h8000_0000) ? 32'h8000_0000 : (32'd0 - mag[31:0]);
        end
        return res;
    endfunction

    logic [31:0] f32_q, f64_q, pcm_q;

    // single precision
    always_comb begin
        logic        neg;
        logic [7:0]  e, ee, k, s;
        logic [22:0] m;
        logic [23:0] mant;
        logic [63:0] mag;
        neg  = i_raw[31];
        e    = i_raw[30:23];
        m    = i_raw[22:0];
        mant = {(e != 8'd0), m};
        ee   = (e == 8'd0) ? 8'd1 : e;
        k    = ee - 8'd119;
        s    = 8'd119 - ee;
        if (ee >= 8'd119) begin
            mag = (k > 8'd8) ? {24'd0, BIG} : ({40'd0, mant} << k[3:0]);
        end else begin
            mag = (s >= 8'd24) ? 64'd0 : ({40'd0, mant} >> s[4:0]);
        end
        if (e == 8'hFF) begin
            f32_q = (m != 23'd0) ? 32'd0 : sat_q31(neg, {24'd0, BIG});
        end else begin
            f32_q = sat_q31(neg, mag);
        end
    end

    // double precision
    always_comb begin
        logic        neg;
        logic [10:0] e, ee, s;
        logic [51:0] m;
        logic [52:0] mant;
        logic [63:0] mag;
        neg  = i_raw[63];
        e    = i_raw[62:52];
        m    = i_raw[51:0];
        mant = {(e != 11'd0), m};
        ee   = (e == 11'd0) ? 11'd1 : e;
        s    = 11'd1044 - ee;
        if (ee >= 11'd1044) begin
            mag = {24'd0, BIG};
        end else begin
            mag = (s >= 11'd53) ? 64'd0 : ({11'd0, mant} >> s[5:0]);
        end
        if (e == 11'h7FF && m != 52'd0) begin
            f64_q = 32'd0;
        end else begin
            f64_q = sat_q31(neg, mag);
        end
    end

    // integer PCM placement
    always_comb begin
        case (i_bits)
            7'd8:    pcm_q = {i_raw[7:0] ^ 8'h80, 24'd0};
            7'd16:   pcm_q = {i_raw[15:0], 16'd0};
            7'd24:   pcm_q = {i_raw[23:0], 8'd0};
            default: pcm_q = i_raw[31:0];
        endcase
    end

    assign o_q31 = !i_is_float ? pcm_q : ((i_bits == 7'd32) ? f32_q : f64_q);

endmodule

// ===== sv/wsd_parser.sv =====
// Byte parser: RIFF header, chunk walk, fmt decode and frame assembly.
module wsd_parser #(
    parameter int MAX_CHANNELS = 8,
    parameter int IW   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1,
    parameter int CNTW = $clog2(MAX_CHANNELS + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_acc,
    input  logic [7:0]        i_byte,
    input  logic              i_eof,
    output wsd_pkg::t_grp     o_grp,
    output logic              o_any,
    output logic [CNTW-1:0]   o_nsamp,
    output logic              o_wr_en,
    output logic [IW-1:0]     o_wr_idx,
    output logic [31:0]       o_wr_data
);

    localparam logic [15:0] MAXC = 16'(MAX_CHANNELS);

    wsd_pkg::t_phase r_phase, n_phase;
    logic [5:0]  r_fcnt, n_fcnt;
    logic [31:0] r_tag, n_tag, r_rem, n_rem;
    logic        r_odd, n_odd;
    logic [15:0] r_ftag, n_ftag, r_sub, n_sub, r_chans, n_chans, r_bits, n_bits;
    logic [31:0] r_rate, n_rate;
    logic        r_float, n_float, r_fmt_seen, n_fmt_seen, r_data_seen, n_data_seen;
    logic [63:0] r_shift, n_shift;
    logic [2:0]  r_bidx, n_bidx;
    logic [IW-1:0] r_chidx, n_chidx;
    logic [31:0] r_frames, n_frames;
    logic        r_err, n_err;

    logic [63:0] conv_raw;
    logic [31:0] conv_q;

    // current sample word with this byte merged into its lane
    assign conv_raw = r_shift | ({56'd0, i_byte} << {r_bidx, 3'b000});

    wsd_conv u_conv (
        .i_raw      (conv_raw),
        .i_bits     (r_bits[6:0]),
        .i_is_float (r_float),
        .o_q31      (conv_q)
    );

    assign o_wr_data = conv_q;
    assign o_wr_idx  = r_chidx;

    // next state and results for one byte
    always_comb begin
        logic [5:0]  p, pinc;
        logic        start_chk, end_chk, ok;
        logic [15:0] t;
        logic [3:0]  bps;
        n_phase = r_phase; n_fcnt = r_fcnt; n_tag = r_tag; n_rem = r_rem; n_odd = r_odd;
        n_ftag = r_ftag; n_sub = r_sub; n_chans = r_chans; n_bits = r_bits;
        n_rate = r_rate; n_float = r_float; n_fmt_seen = r_fmt_seen;
        n_data_seen = r_data_seen; n_shift = r_shift; n_bidx = r_bidx;
        n_chidx = r_chidx; n_frames = r_frames; n_err = r_err;
        o_grp = '0; o_wr_en = 1'b0; o_nsamp = '0;
        start_chk = 1'b0; end_chk = 1'b0; ok = 1'b1; t = '0;
        p    = r_fcnt;
        pinc = (r_fcnt == 6'd63) ? 6'd63 : r_fcnt + 6'd1;
        bps  = r_bits[6:3];

        case (r_phase)
            wsd_pkg::PH_HEADER: begin
                n_tag  = {i_byte, r_tag[31:8]};
                n_fcnt = pinc;
                if (p == 6'd3 && n_tag != wsd_pkg::TAG_RIFF) begin
                    n_err = 1'b1; n_phase = wsd_pkg::PH_DEAD;
                end
                if (p == 6'd11) begin
                    if (n_tag != wsd_pkg::TAG_WAVE) begin
                        n_err = 1'b1; n_phase = wsd_pkg::PH_DEAD;
                    end else begin
                        n_phase = wsd_pkg::PH_CHDR; n_fcnt = '0;
                    end
                end
            end
            wsd_pkg::PH_CHDR: begin
                if (p < 6'd4) n_tag = {i_byte, r_tag[31:8]};
                else          n_rem = {i_byte, r_rem[31:8]};
                n_fcnt = pinc;
                if (p >= 6'd7) start_chk = 1'b1;
            end
            wsd_pkg::PH_FMT, wsd_pkg::PH_DATA, wsd_pkg::PH_SKIP: begin
                if (r_phase == wsd_pkg::PH_FMT) begin
                    case (p)
                        6'd0:  n_ftag[7:0]   = i_byte;
                        6'd1:  n_ftag[15:8]  = i_byte;
                        6'd2:  n_chans       = {8'd0, i_byte};
                        6'd3:  n_chans[15:8] = i_byte;
                        6'd4:  n_rate[7:0]   = i_byte;
                        6'd5:  n_rate[15:8]  = i_byte;
                        6'd6:  n_rate[23:16] = i_byte;
                        6'd7:  n_rate[31:24] = i_byte;
                        6'd14: n_bits        = {8'd0, i_byte};
                        6'd15: n_bits[15:8]  = i_byte;
                        6'd24: n_sub         = {8'd0, i_byte};
                        6'd25: n_sub[15:8]   = i_byte;
                        default: ;
                    endcase
                end else if (r_phase == wsd_pkg::PH_DATA) begin
                    if ({1'b0, r_bidx} + 4'd1 < bps) begin
                        n_shift = conv_raw;
                        n_bidx  = r_bidx + 3'd1;
                    end else begin
                        o_wr_en = 1'b1;
                        n_shift = '0;
                        n_bidx  = '0;
                        if (17'(r_chidx) + 17'd1 >= {1'b0, r_chans}) begin
                            o_grp.frame = 1'b1;
                            if (r_frames != 32'hFFFF_FFFF) n_frames = r_frames + 32'd1;
                            n_chidx = '0;
                        end else begin
                            n_chidx = r_chidx + IW'(1);
                        end
                    end
                end
                n_fcnt = pinc;
                n_rem  = r_rem - 32'd1;
                if (n_rem == 32'd0) end_chk = 1'b1;
            end
            wsd_pkg::PH_PAD: begin
                n_phase = wsd_pkg::PH_CHDR;
                n_fcnt  = '0;
            end
            default: ;
        endcase

        // chunk header complete
        if (start_chk) begin
            n_odd  = n_rem[0];
            n_fcnt = '0;
            if (n_tag == wsd_pkg::TAG_FMT && !r_data_seen) begin
                n_phase = wsd_pkg::PH_FMT;
                n_ftag = '0; n_sub = '0; n_chans = '0; n_bits = '0;
                n_rate = '0; n_float = 1'b0;
            end else if (n_tag == wsd_pkg::TAG_DATA && r_fmt_seen && !r_data_seen) begin
                n_data_seen = 1'b1;
                n_phase = r_err ? wsd_pkg::PH_SKIP : wsd_pkg::PH_DATA;
                n_shift = '0; n_bidx = '0; n_chidx = '0;
            end else begin
                n_phase = wsd_pkg::PH_SKIP;
            end
            if (n_rem == 32'd0) end_chk = 1'b1;
        end

        // chunk body complete; close out fmt
        if (end_chk) begin
            if (n_phase == wsd_pkg::PH_FMT) begin
                t  = n_ftag;
                ok = (n_fcnt >= wsd_pkg::FMT_MIN_SIZE);
                if (t == wsd_pkg::FMT_EXT) begin
                    if (n_fcnt < wsd_pkg::EXT_MIN_SIZE) ok = 1'b0;
                    t = n_sub;
                end
                n_float = (t == wsd_pkg::FMT_FLOAT);
                if (t != wsd_pkg::FMT_FLOAT && t != wsd_pkg::FMT_PCM) ok = 1'b0;
                if (n_chans == 16'd0 || n_chans > MAXC) ok = 1'b0;
                if (n_rate == 32'd0) ok = 1'b0;
                if (n_float) begin
                    if (n_bits != 16'd32 && n_bits != 16'd64) ok = 1'b0;
                end else if (n_bits != 16'd8 && n_bits != 16'd16 &&
                             n_bits != 16'd24 && n_bits != 16'd32) begin
                    ok = 1'b0;
                end
                if (!ok) n_err = 1'b1;
                n_fmt_seen    = 1'b1;
                o_grp.fmt     = 1'b1;
                o_grp.fmt_err = n_err;
            end
            n_shift = '0; n_bidx = '0; n_chidx = '0; n_fcnt = '0;
            n_phase = n_odd ? wsd_pkg::PH_PAD : wsd_pkg::PH_CHDR;
        end

        // format snapshot for the report beats
        o_grp.chans    = (n_chans[15:4] != 12'd0) ? 4'hF : n_chans[3:0];
        o_grp.rate     = n_rate;
        o_grp.bits     = (n_bits[15:7] != 9'd0) ? 7'h7F : n_bits[6:0];
        o_grp.is_float = n_float;
        o_nsamp        = n_chans[CNTW-1:0];

        // end of file: finish report, then start over
        if (i_eof) begin
            o_grp.fin     = 1'b1;
            o_grp.fin_err = n_err || !n_fmt_seen || !n_data_seen || (n_frames == 32'd0);
            o_grp.frames  = n_frames;
            n_phase = wsd_pkg::PH_HEADER; n_fcnt = '0; n_tag = '0; n_rem = '0;
            n_odd = 1'b0; n_ftag = '0; n_sub = '0; n_chans = '0; n_bits = '0;
            n_rate = '0; n_float = 1'b0; n_fmt_seen = 1'b0; n_data_seen = 1'b0;
            n_shift = '0; n_bidx = '0; n_chidx = '0; n_frames = '0; n_err = 1'b0;
        end

        o_any = o_grp.frame | o_grp.fmt | o_grp.fin;
    end

    // state registers, updated per accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= wsd_pkg::PH_HEADER; r_fcnt <= '0; r_tag <= '0; r_rem <= '0;
            r_odd <= 1'b0; r_ftag <= '0; r_sub <= '0; r_chans <= '0; r_bits <= '0;
            r_rate <= '0; r_float <= 1'b0; r_fmt_seen <= 1'b0; r_data_seen <= 1'b0;
            r_shift <= '0; r_bidx <= '0; r_chidx <= '0; r_frames <= '0; r_err <= 1'b0;
        end else if (i_acc) begin
            r_phase <= n_phase; r_fcnt <= n_fcnt; r_tag <= n_tag; r_rem <= n_rem;
            r_odd <= n_odd; r_ftag <= n_ftag; r_sub <= n_sub; r_chans <= n_chans;
            r_bits <= n_bits; r_rate <= n_rate; r_float <= n_float;
            r_fmt_seen <= n_fmt_seen; r_data_seen <= n_data_seen; r_shift <= n_shift;
            r_bidx <= n_bidx; r_chidx <= n_chidx; r_frames <= n_frames; r_err <= n_err;
        end
    end

endmodule

// ===== sv/wsd_emitter.sv =====
// Result emitter: frame store and serializer of the beats raised by one byte.
module wsd_emitter #(
    parameter int MAX_CHANNELS = 8,
    parameter int IW   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1,
    parameter int CNTW = $clog2(MAX_CHANNELS + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    output logic               o_acc,
    input  wsd_pkg::t_grp      i_grp,
    input  logic               i_any,
    input  logic [CNTW-1:0]    i_nsamp,
    input  logic               i_wr_en,
    input  logic [IW-1:0]      i_wr_idx,
    input  logic [31:0]        i_wr_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output wsd_pkg::t_out_beat o_out_data
);

    logic [31:0]     r_store [MAX_CHANNELS];
    logic [CNTW-1:0] r_nleft;
    logic [IW-1:0]   r_ch;
    logic            r_pfmt, r_pfin;
    wsd_pkg::t_grp   r_grp;
    logic            last, out_acc;

    // pending beats and the final one of the run
    assign o_out_valid = (r_nleft != '0) | r_pfmt | r_pfin;
    assign last = ((r_nleft == CNTW'(1)) & !r_pfmt & !r_pfin) |
                  ((r_nleft == '0) & (r_pfmt ^ r_pfin));
    assign out_acc    = o_out_valid & !i_out_stall;
    assign o_in_stall = o_out_valid & !(last & !i_out_stall);
    assign o_acc      = i_in_valid & !o_in_stall;

    // frame store writes
    always_ff @(posedge i_clk) begin
        if (o_acc && i_wr_en) begin
            r_store[i_wr_idx] <= i_wr_data;
        end
    end

    // run bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nleft <= '0;
            r_ch    <= '0;
            r_pfmt  <= 1'b0;
            r_pfin  <= 1'b0;
        end else if (o_acc && i_any) begin
            r_nleft <= i_grp.frame ? i_nsamp : '0;
            r_ch    <= '0;
            r_pfmt  <= i_grp.fmt;
            r_pfin  <= i_grp.fin;
        end else if (out_acc) begin
            if (r_nleft != '0) begin
                r_nleft <= r_nleft - CNTW'(1);
                r_ch    <= r_ch + IW'(1);
            end else if (r_pfmt) begin
                r_pfmt <= 1'b0;
            end else begin
                r_pfin <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_acc && i_any) r_grp <= i_grp;
    end

    // output beat
    always_comb begin
        o_out_data = '0;
        o_out_data.last_of_run = last;
        if (r_nleft != '0) begin
            o_out_data.kind    = wsd_pkg::KIND_SAMPLE;
            o_out_data.sample  = r_store[r_ch];
            o_out_data.channel = 3'(r_ch);
        end else begin
            o_out_data.kind            = r_pfmt ? wsd_pkg::KIND_FORMAT : wsd_pkg::KIND_FINISH;
            o_out_data.format_channels = r_grp.chans;
            o_out_data.format_rate     = r_grp.rate;
            o_out_data.format_bits     = r_grp.bits;
            o_out_data.format_is_float = r_grp.is_float;
            o_out_data.error           = r_pfmt ? r_grp.fmt_err : r_grp.fin_err;
            o_out_data.frame_count     = r_pfmt ? 32'd0 : r_grp.frames;
        end
    end

    // no new byte while more than one beat of the run is left
    a_hold_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !last) |-> o_in_stall)
        else $error("byte accepted while run still pending");

    // taking a non-final beat leaves the run pending
    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && !last) |=> o_out_valid)
        else $error("run ended early");

    // finish beat always closes the run
    a_finish_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.kind == wsd_pkg::KIND_FINISH) |-> last)
        else $error("finish beat not last of run");

endmodule
